// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_NORST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ===== rtl/ifr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ifr_pkg;

    localparam int MAX_DIM     = 256;
    localparam int CHANNELS    = 4;
    localparam int PIX_W       = 32;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int CFG_W       = DIM_W + 1;
    localparam int ADDR_W      = 2 * DIM_W;
    localparam int TOTAL_W     = ADDR_W + 1;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_Q_DEPTH = 4;
    localparam int OUT_Q_AW    = $clog2(OUT_Q_DEPTH);

    localparam logic [PIX_W-1:0] PIXEL_MASK =
        (CHANNELS >= 4) ? {PIX_W{1'b1}} : PIX_W'((64'd1 << (8 * CHANNELS)) - 64'd1);

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFORM_MODE = 2'd2;

    typedef enum logic [1:0] {
        MODE_FLIP_V  = 2'd0,
        MODE_FLIP_H  = 2'd1,
        MODE_ROT_CW  = 2'd2,
        MODE_ROT_CCW = 2'd3
    } t_mode;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_in;
    } t_in_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_of_frame;
    } t_out_item;

    // Out-of-range dimensions: zero acts as one, anything too large as the maximum.
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            res = CFG_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ifr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ifr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read and a write to the same entry on one edge return the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/image_flip_rotate_90_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame store that flips or rotates an image by 90 degrees. Load beats (operation 0) write
// source pixels in raster order; emit beats (operation 1) return one output pixel each, in
// output raster order, with last_of_frame on the final pixel. One beat is taken per clock
// while the output side keeps up. An emit result passes an address register, the store's
// registered read port and a four-entry output queue, and is offered once it is queued.
// The input stalls while four results are queued or in flight, while reset is held, in
// the cycle after reset is released, and in the cycle after each configuration write
// while the frame size product is recomputed. The store holds MAX_DIM * MAX_DIM words and
// is not cleared: pixels never loaded read back as undefined data.
module image_flip_rotate_90_core import ifr_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]   r_width, n_width;
    logic [CFG_W-1:0]   r_height, n_height;
    t_mode              r_mode, n_mode;
    logic [TOTAL_W-1:0] r_total;
    logic               r_cfg_hold;
    logic [ADDR_W-1:0]  r_load_pos, n_load_pos;
    logic [DIM_W-1:0]   r_col, n_col;
    logic [DIM_W-1:0]   r_row, n_row;

    logic               r_a_valid;
    logic [DIM_W-1:0]   r_a_sx;
    logic [DIM_W-1:0]   r_a_sy;
    logic               r_a_last;
    logic               r_b_valid;
    logic               r_b_last;

    t_out_item          r_q_mem [OUT_Q_DEPTH];
    logic [OUT_Q_AW-1:0] r_q_wr, n_q_wr;
    logic [OUT_Q_AW-1:0] r_q_rd, n_q_rd;
    logic [OUT_Q_AW:0]   r_q_count, n_q_count;

    logic [CFG_W-1:0]    wc, hc;
    logic [2*CFG_W-1:0]  total_full;
    logic [DIM_W-1:0]    wm1, hm1, owm1, ohm1;
    logic [DIM_W-1:0]    c_cur, r_cur, sx, sy;
    logic                emit_last;
    logic                accept, do_load, do_emit;
    logic [ADDR_W-1:0]   load_addr;
    logic [TOTAL_W-1:0]  load_inc;
    logic [ADDR_W-1:0]   rd_addr;
    logic [PIX_W-1:0]    ram_rdata;
    logic [OUT_Q_AW+1:0] occupancy;
    logic                q_push, q_pop;

    assign wc = clamp_dim(r_width);
    assign hc = clamp_dim(r_height);
    assign total_full = (2*CFG_W)'(wc) * (2*CFG_W)'(hc);
    assign wm1 = DIM_W'(wc - 1'b1);
    assign hm1 = DIM_W'(hc - 1'b1);
    assign owm1 = r_mode[1] ? hm1 : wm1;
    assign ohm1 = r_mode[1] ? wm1 : hm1;

    // Results queued plus those still in the address and read stages.
    assign occupancy = (OUT_Q_AW+2)'(r_q_count) + (OUT_Q_AW+2)'(r_a_valid)
                     + (OUT_Q_AW+2)'(r_b_valid);
    assign o_in_stall = !i_rst_n || r_cfg_hold || (occupancy >= (OUT_Q_AW+2)'(OUT_Q_DEPTH));
    assign accept  = i_in_valid && !o_in_stall;
    assign do_load = accept && (i_in_data.operation == OP_LOAD);
    assign do_emit = accept && (i_in_data.operation == OP_EMIT);

    // Load position, restarted when it lies beyond a frame that has since shrunk.
    always_comb begin
        load_addr = ({1'b0, r_load_pos} >= r_total) ? '0 : r_load_pos;
        load_inc  = {1'b0, load_addr} + TOTAL_W'(1);
        n_load_pos = r_load_pos;
        if (do_load) begin
            n_load_pos = (load_inc >= r_total) ? '0 : load_inc[ADDR_W-1:0];
        end
    end

    always_comb begin
        if ((r_col > owm1) || (r_row > ohm1)) begin
            c_cur = '0;
            r_cur = '0;
        end else begin
            c_cur = r_col;
            r_cur = r_row;
        end

        unique case (r_mode)
            MODE_FLIP_V: begin
                sx = c_cur;
                sy = hm1 - r_cur;
            end
            MODE_FLIP_H: begin
                sx = wm1 - c_cur;
                sy = r_cur;
            end
            MODE_ROT_CW: begin
                sx = r_cur;
                sy = hm1 - c_cur;
            end
            MODE_ROT_CCW: begin
                sx = wm1 - r_cur;
                sy = c_cur;
            end
        endcase

        emit_last = (c_cur == owm1) && (r_cur == ohm1);

        n_col = r_col;
        n_row = r_row;
        if (do_emit) begin
            if (c_cur == owm1) begin
                n_col = '0;
                n_row = (r_cur == ohm1) ? '0 : r_cur + 1'b1;
            end else begin
                n_col = c_cur + 1'b1;
                n_row = r_cur;
            end
        end
    end

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_mode   = r_mode;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:    n_width  = i_cfg_data;
                CFG_IMAGE_HEIGHT:   n_height = i_cfg_data;
                CFG_TRANSFORM_MODE: n_mode   = t_mode'(i_cfg_data[1:0]);
                default:            n_mode   = r_mode;
            endcase
        end
    end

    // The source row times the width; sy stays below the height, so this fits the store.
    assign rd_addr = ADDR_W'(r_a_sy) * ADDR_W'(wc) + ADDR_W'(r_a_sx);

    ifr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_load),
        .i_waddr (load_addr),
        .i_wdata (i_in_data.pixel_in & PIXEL_MASK),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    assign q_push = r_b_valid;
    assign q_pop  = o_out_valid && !i_out_stall;

    always_comb begin
        n_q_wr    = q_push ? r_q_wr + 1'b1 : r_q_wr;
        n_q_rd    = q_pop ? r_q_rd + 1'b1 : r_q_rd;
        n_q_count = r_q_count + (OUT_Q_AW+1)'(q_push) - (OUT_Q_AW+1)'(q_pop);
    end

    assign o_out_valid = i_rst_n && (r_q_count != '0);
    assign o_out_data  = r_q_mem[r_q_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= CFG_W'(MAX_DIM);
            r_height   <= CFG_W'(MAX_DIM);
            r_mode     <= MODE_FLIP_V;
            r_total    <= TOTAL_W'(STORE_DEPTH);
            r_cfg_hold <= 1'b1;
            r_load_pos <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_q_wr     <= '0;
            r_q_rd     <= '0;
            r_q_count  <= '0;
        end else begin
            r_width    <= n_width;
            r_height   <= n_height;
            r_mode     <= n_mode;
            r_total    <= total_full[TOTAL_W-1:0];
            r_cfg_hold <= i_cfg_we;
            r_load_pos <= n_load_pos;
            r_col      <= n_col;
            r_row      <= n_row;
            r_a_valid  <= do_emit;
            r_b_valid  <= r_a_valid;
            r_q_wr     <= n_q_wr;
            r_q_rd     <= n_q_rd;
            r_q_count  <= n_q_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_emit) begin
            r_a_sx   <= sx;
            r_a_sy   <= sy;
            r_a_last <= emit_last;
        end
        r_b_last <= r_a_last;
        if (q_push) begin
            r_q_mem[r_q_wr] <= '{pixel_out: ram_rdata, last_of_frame: r_b_last};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ifr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ifr_checker import ifr_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data,
    input wire logic      i_cfg_we
);

    // A result that is held back stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))

    // The frame size is recomputed in the cycle after a register write, so no beat is taken.
    `ASSERT_NEXT(a_cfg_gap, i_clk, i_rst_n, i_cfg_we, o_in_stall)

    // Reset empties the output queue.
    `ASSERT_NEXT_NORST(a_rst_empty, i_clk, !i_rst_n, !o_out_valid)

    // Nothing is taken while the block is held in reset.
    `ASSERT_IMPL(a_in_idle, i_clk, 1'b1, !i_rst_n && i_in_valid, o_in_stall)

endmodule

bind image_flip_rotate_90_core ifr_checker u_ifr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we)
);

`default_nettype wire
